// File: rtl/aes128_cmac_engine_macros.svh
// Assertion macros shared by the CMAC engine modules.
`ifndef AES128_CMAC_ENGINE_MACROS_SVH
`define AES128_CMAC_ENGINE_MACROS_SVH
`ifndef SYNTHESIS
`define CMAC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define CMAC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define CMAC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define CMAC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/acmac_pkg.sv
// Types, tables and round functions of the CMAC engine.
package acmac_pkg;

  localparam int unsigned NumRounds = 10;
  localparam int unsigned RkDepth   = NumRounds + 1;
  localparam int unsigned RkAw      = 4;

  localparam logic [0:0] RegKeyUpper = 1'b0;
  localparam logic [0:0] RegKeyLower = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_KEXP,
    ST_SUBK,
    ST_LOAD,
    ST_RUN,
    ST_OUT
  } cmac_state_t;

  // Round key store request from controller to key expansion
  typedef struct packed {
    logic             start;
    logic [127:0]     key;
  } kexp_req_t;

  typedef struct packed {
    logic             wr_en;
    logic [RkAw-1:0]  wr_addr;
    logic [127:0]     wr_data;
    logic             done;
  } kexp_rsp_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    return t[a];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  // One round without key addition; byte 0 in bits 127:120
  function automatic logic [127:0] aes_round(input logic [127:0] st, input logic last);
    logic [7:0] s [16];
    logic [7:0] p [16];
    logic [7:0] a;
    logic [127:0] r;
    for (int i = 0; i < 16; i++) s[i] = sbox(st[127-8*i -: 8]);
    for (int c = 0; c < 4; c++)
      for (int i = 0; i < 4; i++) p[4*c+i] = s[(4*(c+i)+i) % 16];
    for (int c = 0; c < 4; c++) begin
      a = p[4*c] ^ p[4*c+1] ^ p[4*c+2] ^ p[4*c+3];
      for (int i = 0; i < 4; i++) begin
        if (last) r[127-8*(4*c+i) -: 8] = p[4*c+i];
        else r[127-8*(4*c+i) -: 8] = p[4*c+i] ^ a ^
          xtime(p[4*c+i] ^ p[4*c+((i+1)%4)]);
      end
    end
    return r;
  endfunction

  // Next round key from the previous one
  function automatic logic [127:0] key_step(input logic [127:0] k, input logic [7:0] rc);
    logic [31:0] t;
    logic [31:0] w0, w1, w2, w3;
    t = {sbox(k[23:16]) ^ rc, sbox(k[15:8]), sbox(k[7:0]), sbox(k[31:24])};
    w0 = k[127:96] ^ t;
    w1 = k[95:64] ^ w0;
    w2 = k[63:32] ^ w1;
    w3 = k[31:0] ^ w2;
    return {w0, w1, w2, w3};
  endfunction

  function automatic logic [127:0] dbl128(input logic [127:0] v);
    return {v[126:0], 1'b0} ^ (v[127] ? 128'h87 : 128'h0);
  endfunction

endpackage

// File: rtl/acmac_kexp.sv
// Key expansion sequencer: writes one round key per cycle.
module acmac_kexp
  import acmac_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  kexp_req_t req,
  output kexp_rsp_t rsp
);

  logic [127:0]    k_r, k_nxt;
  logic [RkAw-1:0] idx_r, idx_nxt;
  logic [7:0]      rc_r, rc_nxt;
  logic            busy_r, busy_nxt;

  // Walk round keys 0..10
  always_comb begin
    k_nxt = k_r;
    idx_nxt = idx_r;
    rc_nxt = rc_r;
    busy_nxt = busy_r;
    rsp = '0;
    if (req.start) begin
      k_nxt = req.key;
      idx_nxt = '0;
      rc_nxt = 8'h01;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rsp.wr_en = 1'b1;
      rsp.wr_addr = idx_r;
      rsp.wr_data = k_r;
      k_nxt = key_step(k_r, rc_r);
      rc_nxt = xtime(rc_r);
      idx_nxt = idx_r + 1'b1;
      if (idx_r == RkAw'(RkDepth - 1)) begin
        busy_nxt = 1'b0;
        rsp.done = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      idx_r <= idx_nxt;
    end
    k_r <= k_nxt;
    rc_r <= rc_nxt;
  end

endmodule

// File: rtl/acmac_core.sv
// Round key memory and iterative AES round unit.
module acmac_core
  import acmac_pkg::*;
`include "aes128_cmac_engine_macros.svh"
(
  input  logic            clk,
  input  logic            rst_n,
  input  kexp_rsp_t       kw,
  input  logic            load,
  input  logic [127:0]    blk,
  output logic            done,
  output logic [127:0]    res
);

  logic [127:0]    rk_mem [RkDepth];
  logic [127:0]    rk_q_r;
  logic [RkAw-1:0] rd_addr;
  logic [RkAw-1:0] rnd_r, rnd_nxt;
  logic            run_r, run_nxt;
  logic [127:0]    st_r, st_nxt;
  logic            done_r, done_nxt;

  // Round key memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (kw.wr_en) rk_mem[kw.wr_addr] <= kw.wr_data;
    rk_q_r <= rk_mem[rd_addr];
  end

  // Load fetches key 0; each round cycle fetches the next key
  always_comb begin
    rd_addr = (load || rnd_r >= RkAw'(RkDepth)) ? '0 : rnd_r;
    st_nxt = st_r;
    rnd_nxt = rnd_r;
    run_nxt = run_r;
    done_nxt = 1'b0;
    if (load) begin
      st_nxt = blk;
      rnd_nxt = RkAw'(1);
      run_nxt = 1'b1;
    end else if (run_r) begin
      // rk_q_r holds key rnd_r-1
      if (rnd_r == RkAw'(1)) st_nxt = st_r ^ rk_q_r;
      else st_nxt = aes_round(st_r, 1'b0) ^ rk_q_r;
      if (rnd_r == RkAw'(RkDepth)) begin
        st_nxt = aes_round(st_r, 1'b1) ^ rk_q_r;
        run_nxt = 1'b0;
        done_nxt = 1'b1;
      end
      rnd_nxt = rnd_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      done_r <= 1'b0;
      rnd_r <= '0;
    end else begin
      run_r <= run_nxt;
      done_r <= done_nxt;
      rnd_r <= rnd_nxt;
    end
    st_r <= st_nxt;
  end

  assign done = done_r;
  assign res = st_r;

  `CMAC_ASSERT_NEXT(a_done_ends_run, clk, rst_n, done_r, !run_r || load)
  `CMAC_ASSERT_IMPL(a_run_rnd_range, clk, rst_n, run_r, rnd_r != '0)
  `CMAC_ASSERT_IMPL(a_no_wr_while_run, clk, rst_n, run_r, !kw.wr_en)

endmodule

// File: rtl/aes128_cmac_engine.sv
// Top level of the AES-128 CMAC engine.
// Usage:
//  cfg_*: write key_upper (index 0) or key_lower (index 1) while idle;
//         any key write forces a new key setup before the next block.
//  in_*:  one 16-byte block per item; tlast marks the final block,
//         tuser gives its valid byte count (0..16).
//  out_*: one 128-bit tag per message, after the final block.
// Flow: each accepted block passes through a load step, key addition and
// ten rounds (one per cycle from the round key memory), a step to take
// the result and an idle step before the next block can be accepted. The
// tag is taken from the round unit once the final block's last round is
// done. The first block after reset or a key write is preceded by key
// expansion and subkey encryption. Blocks are handled one at a time
// because each depends on the chaining value of the previous one.
// Reset clears control state, the chaining value and the key registers.
// A stalled receiver holds the tag in the output register while the next
// message proceeds; a second tag waits in the round unit until the first
// is delivered, and no block is taken meanwhile.
module aes128_cmac_engine
  import acmac_pkg::*;
`include "aes128_cmac_engine_macros.svh"
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [0:0]   cfg_index,
  input  logic [63:0]  cfg_data,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // data_upper[63:0], data_lower[127:64]
  input  logic         in_tlast,   // final_block
  input  logic [4:0]   in_tuser,   // valid_bytes
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata   // tag_upper[63:0], tag_lower[127:64]
);

  cmac_state_t  st_r, st_nxt;
  logic [63:0]  key_up_r, key_lo_r;
  logic         ready_r, ready_nxt;
  logic [127:0] cv_r, cv_nxt;
  logic [127:0] k1_r, k1_nxt, k2_r, k2_nxt;
  logic [127:0] blk_r, blk_nxt;
  logic         fin_r, fin_nxt;
  logic [127:0] tag_r, tag_nxt;
  logic         tv_r, tv_nxt;
  logic         subk_r, subk_nxt;
  kexp_req_t    kreq;
  kexp_rsp_t    krsp;
  logic         load;
  logic [127:0] core_in;
  logic         core_done;
  logic [127:0] core_res;
  logic [127:0] din, pad;
  logic [127:0] l_dbl;
  logic         in_acc;

  assign cfg_ready = 1'b1;
  assign din = {in_tdata[63:0], in_tdata[127:64]};

  // Pad a partial final block: keep valid bytes, then 0x80, then zeros
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      if (i < int'(in_tuser)) pad[127-8*i -: 8] = din[127-8*i -: 8];
      else if (i == int'(in_tuser)) pad[127-8*i -: 8] = 8'h80;
      else pad[127-8*i -: 8] = 8'h00;
    end
  end

  acmac_kexp u_kexp (.clk(clk), .rst_n(rst_n), .req(kreq), .rsp(krsp));

  acmac_core u_core (
    .clk(clk), .rst_n(rst_n), .kw(krsp), .load(load), .blk(core_in),
    .done(core_done), .res(core_res)
  );

  assign l_dbl = dbl128(core_res);
  assign in_acc = in_tvalid && in_tready;
  assign out_tvalid = tv_r;
  assign out_tdata = {tag_r[63:0], tag_r[127:64]};

  // Sequence key setup, block encryption and tag hand-off
  always_comb begin
    st_nxt = st_r;
    ready_nxt = ready_r;
    cv_nxt = cv_r;
    k1_nxt = k1_r;
    k2_nxt = k2_r;
    blk_nxt = blk_r;
    fin_nxt = fin_r;
    tag_nxt = tag_r;
    tv_nxt = tv_r;
    subk_nxt = subk_r;
    kreq.start = 1'b0;
    kreq.key = {key_up_r, key_lo_r};
    load = 1'b0;
    core_in = blk_r;
    in_tready = 1'b0;
    if (tv_r && out_tready) tv_nxt = 1'b0;
    case (st_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_acc) begin
          fin_nxt = in_tlast;
          if (!in_tlast) blk_nxt = din;
          else if (in_tuser >= 5'd16) blk_nxt = din;
          else blk_nxt = pad;
          if (ready_r) st_nxt = ST_LOAD;
          else begin
            kreq.start = 1'b1;
            st_nxt = ST_KEXP;
          end
        end
      end
      ST_KEXP: begin
        if (krsp.done) begin
          load = 1'b1;
          core_in = '0;
          st_nxt = ST_SUBK;
        end
      end
      ST_SUBK: begin
        if (core_done) begin
          k1_nxt = l_dbl;
          k2_nxt = dbl128(l_dbl);
          ready_nxt = 1'b1;
          st_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        load = 1'b1;
        if (!fin_r) core_in = blk_r ^ cv_r;
        else if (subk_r) core_in = blk_r ^ cv_r ^ k1_r;
        else core_in = blk_r ^ cv_r ^ k2_r;
        st_nxt = ST_RUN;
      end
      ST_RUN: begin
        if (core_done) begin
          if (fin_r) begin
            cv_nxt = '0;
            // Hold the tag in the round unit while the output slot is taken
            if (!tv_r || out_tready) begin
              tag_nxt = core_res;
              tv_nxt = 1'b1;
              st_nxt = ST_IDLE;
            end else st_nxt = ST_OUT;
          end else begin
            cv_nxt = core_res;
            st_nxt = ST_IDLE;
          end
        end
      end
      ST_OUT: begin
        if (!tv_r || out_tready) begin
          tag_nxt = core_res;
          tv_nxt = 1'b1;
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
    // Remember which subkey the captured final block needs
    if (in_acc) subk_nxt = !in_tlast || (in_tuser >= 5'd16);
    if (cfg_valid && cfg_ready) ready_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      ready_r <= 1'b0;
      cv_r <= '0;
      tv_r <= 1'b0;
      key_up_r <= '0;
      key_lo_r <= '0;
    end else begin
      st_r <= st_nxt;
      ready_r <= ready_nxt;
      cv_r <= cv_nxt;
      tv_r <= tv_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          RegKeyUpper: key_up_r <= cfg_data;
          RegKeyLower: key_lo_r <= cfg_data;
          default: ;
        endcase
      end
    end
    k1_r <= k1_nxt;
    k2_r <= k2_nxt;
    blk_r <= blk_nxt;
    fin_r <= fin_nxt;
    tag_r <= tag_nxt;
    subk_r <= subk_nxt;
  end

  `CMAC_ASSERT_IMPL(a_ready_idle_only, clk, rst_n, in_tready, st_r == ST_IDLE)
  `CMAC_ASSERT_NEXT(a_tag_clears_cv, clk, rst_n, st_r == ST_RUN && core_done && fin_r,
                    cv_r == '0)
  `CMAC_ASSERT_IMPL(a_load_state, clk, rst_n, st_r == ST_LOAD, load)

endmodule
